/* rtl/greedy_bipartite_matcher_assert.svh */
`ifndef GREEDY_BIPARTITE_MATCHER_ASSERT_SVH
`define GREEDY_BIPARTITE_MATCHER_ASSERT_SVH
// Concurrent assertion helpers shared by the RTL.
`define GBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/gbm_pkg.sv */
package gbm_pkg;
    localparam int MAX_LEFT  = 32;
    localparam int MAX_RIGHT = 32;
    localparam int LW = $clog2(MAX_LEFT);
    localparam int RW = $clog2(MAX_RIGHT);
    localparam int MAX_PASSES = MAX_RIGHT + 2;
    localparam int PW = $clog2(MAX_PASSES + 1);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_MATCH = 2'd2;

    localparam logic [0:0] REG_LEFT_COUNT  = 1'b0;
    localparam logic [0:0] REG_RIGHT_COUNT = 1'b1;

    typedef logic [MAX_RIGHT-1:0] t_row;

    typedef struct packed {
        logic          we;
        logic [LW-1:0] waddr;
        t_row          wdata;
        logic [LW-1:0] raddr;
    } t_mem_req;

    function automatic logic [RW-1:0] lowest_bit(input t_row v);
        logic [RW-1:0] k;
        k = '0;
        for (int i = MAX_RIGHT - 1; i >= 0; i--) begin
            if (v[i]) begin
                k = RW'(i);
            end
        end
        return k;
    endfunction
endpackage

/* rtl/gbm_adj_ram.sv */
module gbm_adj_ram import gbm_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_row     o_rdata
);
    t_row r_mem [MAX_LEFT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

/* rtl/greedy_bipartite_matcher.sv */
// Greedy bipartite matcher.
// Input words carry a command in i_func with node indices and an edge value.
// A write edge command produces no output word; it reads the row and then
// writes the row back in the adjacency memory.
// A read edge command reads the row from the adjacency memory; in state S_RDD
// its output word is then registered.
// A match command clears the match state and loads all adjacency rows from the
// memory one per cycle into a row cache. It then runs passes over the left
// nodes, one left node per cycle, plus a search over the left nodes in use
// whenever a matched node looks for an unmatched neighbour of its old right
// node; passes repeat until one changes nothing, at most 34 times. It then
// emits one output word per left node in use, one per cycle while the
// receiver does not stall, the final one flagged by o_last_result.
// One command is worked on at a time; the input is stalled while busy.
// The output word sits in a register; while the receiver stalls the block
// waits and holds it unchanged.
// Reset clears the adjacency memory by a clearing pass over all 32 rows,
// during which no input word is accepted, clears the match state and sets both
// counts to 32. Configuration writes are taken at any time.
module greedy_bipartite_matcher import gbm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [5:0]    i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_func,
    input  logic [4:0]    i_left_index,
    input  logic [4:0]    i_right_index,
    input  logic          i_edge_value,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [4:0]    o_out_left,
    output logic [4:0]    o_out_right,
    output logic          o_found,
    output logic          o_last_result
);
    `include "greedy_bipartite_matcher_assert.svh"

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRD   = 4'd2;
    localparam logic [3:0] S_RDD   = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_PASS  = 4'd5;
    localparam logic [3:0] S_SRCH  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_OUTW  = 4'd8;

    logic [3:0]    r_state;
    logic [5:0]    r_lcnt, r_rcnt;
    logic [LW:0]   r_cnt;
    logic [LW-1:0] r_l, r_i;
    logic [PW-1:0] r_pass;
    logic          r_changed;
    logic [LW-1:0] r_li;
    logic [RW-1:0] r_ri;
    logic          r_ev, r_ok;
    t_row          r_cache [MAX_LEFT];
    logic [RW-1:0] r_match [MAX_LEFT];
    logic [MAX_LEFT-1:0]  r_lm;
    t_row          r_rm;
    logic          r_load_v;
    logic [LW-1:0] r_load_a;

    t_mem_req req;
    t_row     rdata;

    gbm_adj_ram u_ram (.i_clk(i_clk), .i_req(req), .o_rdata(rdata));

    logic [LW:0] nl, nr;
    t_row        rmask;
    always_comb begin
        nl = (r_lcnt == 6'd0) ? (LW+1)'(1) :
             (r_lcnt > 6'(MAX_LEFT)) ? (LW+1)'(MAX_LEFT) : (LW+1)'(r_lcnt);
        nr = (r_rcnt == 6'd0) ? (LW+1)'(1) :
             (r_rcnt > 6'(MAX_RIGHT)) ? (LW+1)'(MAX_RIGHT) : (LW+1)'(r_rcnt);
        for (int k = 0; k < MAX_RIGHT; k++) begin
            rmask[k] = (k < int'(nr));
        end
    end

    t_row          cur_row, freeb;
    logic [RW-1:0] cur_r, old_r;
    logic          last_l, last_i, cand;
    always_comb begin
        cur_row = r_cache[r_l] & rmask;
        freeb   = cur_row & ~r_rm;
        cur_r   = lowest_bit(freeb);
        old_r   = r_match[r_l];
        last_l  = ({1'b0, r_l} + 1'b1) == nl;
        last_i  = ({1'b0, r_i} + 1'b1) == nl;
        cand    = (r_i != r_l) && r_cache[r_i][old_r] && rmask[old_r] && !r_lm[r_i];
    end

    logic in_acc, out_acc;
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_comb begin
        req = '0;
        req.raddr = i_left_index;
        if (r_state == S_CLEAR) begin
            req.we = 1'b1;
            req.waddr = r_cnt[LW-1:0];
        end else if (r_state == S_WRD) begin
            req.we = r_ok;
            req.waddr = r_li;
            req.wdata = rdata;
            req.wdata[r_ri] = r_ev;
        end else if (r_state == S_LOAD) begin
            req.raddr = r_cnt[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_load_v <= (r_state == S_LOAD);
        r_load_a <= r_cnt[LW-1:0];
        if (r_load_v) begin
            r_cache[r_load_a] <= rdata;
        end
        if (in_acc) begin
            r_li   <= i_left_index;
            r_ri   <= i_right_index;
            r_ev   <= i_edge_value;
            r_ok   <= ({1'b0, i_left_index} < nl) && ({1'b0, i_right_index} < nr);
        end
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_lcnt  <= 6'd32;
            r_rcnt  <= 6'd32;
            r_lm    <= '0;
            r_rm    <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_LEFT_COUNT) r_lcnt <= i_cfg_data;
                else                               r_rcnt <= i_cfg_data;
            end
            if (out_acc && r_state != S_EMIT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[LW-1:0] == LW'(MAX_LEFT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_func)
                            FUNC_WRITE: r_state <= S_WRD;
                            FUNC_READ:  r_state <= S_RDD;
                            FUNC_MATCH: begin
                                r_state <= S_LOAD;
                                r_cnt   <= '0;
                                r_lm    <= '0;
                                r_rm    <= '0;
                                r_pass  <= '0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WRD: r_state <= S_IDLE;
                S_RDD: begin
                    o_valid       <= 1'b1;
                    o_out_left    <= r_li;
                    o_out_right   <= r_ri;
                    o_found       <= r_ok && rdata[r_ri];
                    o_last_result <= 1'b1;
                    r_state       <= S_OUTW;
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[LW-1:0] == LW'(MAX_LEFT - 1)) begin
                        r_state   <= S_PASS;
                        r_l       <= '0;
                        r_changed <= 1'b0;
                    end
                end
                S_PASS: begin
                    if (r_load_v) begin
                        r_state <= S_PASS;
                    end else if (freeb != '0 && r_lm[r_l]) begin
                        r_i     <= '0;
                        r_state <= S_SRCH;
                    end else begin
                        if (freeb != '0) begin
                            r_match[r_l] <= cur_r;
                            r_lm[r_l]    <= 1'b1;
                            r_rm[cur_r]  <= 1'b1;
                        end
                        if (last_l) begin
                            r_l       <= '0;
                            r_pass    <= r_pass + 1'b1;
                            r_changed <= 1'b0;
                            if (!(r_changed || freeb != '0) ||
                                r_pass == PW'(MAX_PASSES - 1)) begin
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_l <= r_l + 1'b1;
                            if (freeb != '0) begin
                                r_changed <= 1'b1;
                            end
                        end
                    end
                end
                S_SRCH: begin
                    if (cand || last_i) begin
                        if (cand) begin
                            r_match[r_l] <= cur_r;
                            r_match[r_i] <= old_r;
                            r_lm[r_i]    <= 1'b1;
                            r_rm[cur_r]  <= 1'b1;
                        end
                        if (last_l) begin
                            r_l       <= '0;
                            r_pass    <= r_pass + 1'b1;
                            r_changed <= 1'b0;
                            if (!(r_changed || cand) ||
                                r_pass == PW'(MAX_PASSES - 1)) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_PASS;
                            end
                        end else begin
                            r_l       <= r_l + 1'b1;
                            r_changed <= r_changed || cand;
                            r_state   <= S_PASS;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!o_valid || out_acc) begin
                        o_valid       <= 1'b1;
                        o_out_left    <= r_l;
                        o_out_right   <= r_lm[r_l] ? r_match[r_l] : '0;
                        o_found       <= r_lm[r_l];
                        o_last_result <= last_l;
                        r_l           <= r_l + 1'b1;
                        if (last_l) r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    if (!o_valid || out_acc) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GBM_ASSERT_IMP(a_no_accept_busy, r_state != S_IDLE, !in_acc,
        "input accepted while busy")
    `GBM_ASSERT_NXT(a_hold_out, o_valid && i_stall, o_valid && $stable(o_out_left),
        "stalled output word changed")
    `GBM_ASSERT_IMP(a_no_out_clear, r_state == S_CLEAR || r_state == S_LOAD, !o_valid,
        "output word during clear or load")
    `GBM_ASSERT_NXT(a_read_out, r_state == S_RDD, o_valid && o_last_result,
        "read gave no result")
endmodule
